/* hdl/fgrd_pkg.sv */
// Shared types, codes and control program of the glyph run-length decoder.
`default_nettype none

package fgrd_pkg;

    localparam int MAX_DIM_DEF = 256;
    localparam int REMAP_DEPTH = 256;

    // input actions
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_LOAD  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_MAX_COLOR    = 3'd0;
    localparam logic [2:0] CFG_RLE_MODE     = 3'd1;
    localparam logic [2:0] CFG_REMAP_ENABLE = 3'd2;
    localparam logic [2:0] CFG_GLYPH_WIDTH  = 3'd3;
    localparam logic [2:0] CFG_GLYPH_HEIGHT = 3'd4;

    localparam logic [7:0] NOOP_CODE = 8'd128;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
        logic [7:0] remap_index;
        logic [7:0] remap_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  pixel_value;
        logic [15:0] first_position;
        logic [15:0] first_address;
        logic [7:0]  run_count;
        logic        glyph_done;
    } out_item_t;

    // datapath operations
    localparam logic [2:0] OP_NOP   = 3'd0;
    localparam logic [2:0] OP_FETCH = 3'd1;
    localparam logic [2:0] OP_TOTAL = 3'd2;
    localparam logic [2:0] OP_CHECK = 3'd3;
    localparam logic [2:0] OP_DIV   = 3'd4;
    localparam logic [2:0] OP_ADDR  = 3'd5;
    localparam logic [2:0] OP_EMIT  = 3'd6;

    // sequencing
    localparam logic [2:0] BR_NEXT     = 3'd0;
    localparam logic [2:0] BR_GOTO     = 3'd1;
    localparam logic [2:0] BR_WAIT_IN  = 3'd2;
    localparam logic [2:0] BR_TEST     = 3'd3;
    localparam logic [2:0] BR_WAIT_OUT = 3'd4;

    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] STEP_FETCH = 4'd0;
    localparam logic [STEP_W-1:0] STEP_TOTAL = 4'd1;

    typedef struct packed {
        logic [2:0]        op;
        logic [2:0]        br;
        logic [STEP_W-1:0] target;
    } uword_t;

    function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
        uword_t w;
        case (step)
            4'd0:    w = '{op: OP_FETCH, br: BR_WAIT_IN,  target: STEP_TOTAL};
            4'd1:    w = '{op: OP_TOTAL, br: BR_NEXT,     target: STEP_FETCH};
            4'd2:    w = '{op: OP_CHECK, br: BR_TEST,     target: STEP_FETCH};
            4'd3:    w = '{op: OP_DIV,   br: BR_NEXT,     target: STEP_FETCH};
            4'd4:    w = '{op: OP_DIV,   br: BR_NEXT,     target: STEP_FETCH};
            4'd5:    w = '{op: OP_DIV,   br: BR_NEXT,     target: STEP_FETCH};
            4'd6:    w = '{op: OP_DIV,   br: BR_NEXT,     target: STEP_FETCH};
            4'd7:    w = '{op: OP_ADDR,  br: BR_NEXT,     target: STEP_FETCH};
            4'd8:    w = '{op: OP_EMIT,  br: BR_WAIT_OUT, target: STEP_FETCH};
            default: w = '{op: OP_NOP,   br: BR_GOTO,     target: STEP_FETCH};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* hdl/font_glyph_rle_decoder_unit.sv */
// Top level of the glyph run-length decoder: microcoded sequencer and datapath.
`default_nettype none

// Decodes a glyph's coded byte stream into pixel runs (literal pixels or fill
// runs) with value, row-major position, column-major store address, count and
// a glyph-done flag. A start, a remap table load, an unused action or a stream
// byte while no glyph is active passes only the fetch step. A byte that yields
// no run (control byte, no-op, position past a shrunk glyph end) passes fetch,
// total and check; one with a run goes on through divide, address and emit,
// emit waiting for the output register to be taken. The position-by-width
// divide makes four quotient bits per step over four steps, then the address
// multiply. The result register lets the next byte enter while a run waits.
module font_glyph_rle_decoder_unit
    import fgrd_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data,
    input  wire logic      cfg_wr_en,
    input  wire logic [2:0] cfg_index,
    input  wire logic [8:0] cfg_wdata
);

    localparam logic [8:0] MAX_DIM_V = 9'(MAX_DIM);

    logic [STEP_W-1:0] step_reg, step_next;

    logic [7:0] max_color_reg;
    logic       rle_mode_reg;
    logic       remap_en_reg;
    logic [8:0] width_cfg_reg;
    logic [8:0] height_cfg_reg;

    logic [16:0] pos_reg, pos_next;
    logic [7:0]  lit_left_reg, lit_left_next;
    logic [7:0]  fill_len_reg, fill_len_next;
    logic        awaiting_reg, awaiting_next;
    logic        active_reg, active_next;

    logic [7:0]  byte_reg;
    logic [16:0] total_reg;
    logic [7:0]  color_reg;
    logic [7:0]  remap_rdata_reg;
    logic [7:0]  cnt_reg, cnt_next;
    logic [15:0] div_q_reg, div_q_next;
    logic [8:0]  div_r_reg, div_r_next;
    logic [16:0] prod_reg;

    logic        m_valid_reg;
    out_item_t   m_data_reg;

    logic [7:0]  remap_mem [REMAP_DEPTH];

    uword_t      uw;
    logic        in_fire;
    logic        out_free;
    logic        emit_now;
    logic [8:0]  w_eff, h_eff;
    logic [7:0]  color_clamp;
    logic [16:0] left;
    logic [7:0]  cnt_clip;
    logic [16:0] pos_new;
    logic        done_flag;
    out_item_t   out_item;

    assign uw       = ucode_rom(step_reg);
    assign s_ready  = (uw.op == OP_FETCH);
    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // dimensions saturate into 1..MAX_DIM
    always_comb begin
        w_eff = width_cfg_reg;
        if (width_cfg_reg == 9'd0) begin
            w_eff = 9'd1;
        end else if (width_cfg_reg > MAX_DIM_V) begin
            w_eff = MAX_DIM_V;
        end
        h_eff = height_cfg_reg;
        if (height_cfg_reg == 9'd0) begin
            h_eff = 9'd1;
        end else if (height_cfg_reg > MAX_DIM_V) begin
            h_eff = MAX_DIM_V;
        end
    end

    assign color_clamp = (byte_reg > max_color_reg) ? max_color_reg : byte_reg;

    // run clipping and position update
    assign left      = total_reg - pos_reg;
    assign cnt_clip  = ({9'd0, cnt_reg} > left) ? left[7:0] : cnt_reg;
    assign pos_new   = pos_reg + {9'd0, cnt_clip};
    assign done_flag = (pos_new >= total_reg);

    always_comb begin
        out_item.pixel_value    = remap_en_reg ? remap_rdata_reg : color_reg;
        out_item.first_position = pos_reg[15:0];
        out_item.first_address  = prod_reg[15:0] + {8'd0, div_q_reg[7:0]};
        out_item.run_count      = cnt_clip;
        out_item.glyph_done     = done_flag;
    end

    // datapath next state, one operation per control word
    always_comb begin
        logic [9:0] trial;
        logic [8:0] r;
        logic [15:0] q;
        pos_next      = pos_reg;
        lit_left_next = lit_left_reg;
        fill_len_next = fill_len_reg;
        awaiting_next = awaiting_reg;
        active_next   = active_reg;
        cnt_next      = cnt_reg;
        div_q_next    = div_q_reg;
        div_r_next    = div_r_reg;
        emit_now      = 1'b0;
        trial         = '0;
        r             = div_r_reg;
        q             = div_q_reg;
        case (uw.op)
            OP_FETCH: begin
                if (in_fire && s_data.action == ACT_START) begin
                    pos_next      = '0;
                    lit_left_next = '0;
                    fill_len_next = '0;
                    awaiting_next = 1'b0;
                    active_next   = 1'b1;
                end
            end
            OP_TOTAL: begin
                div_q_next = pos_reg[15:0];
                div_r_next = '0;
            end
            OP_CHECK: begin
                if (pos_reg >= total_reg) begin
                    active_next = 1'b0;
                end else if (!rle_mode_reg) begin
                    emit_now = 1'b1;
                    cnt_next = 8'd1;
                end else if (awaiting_reg) begin
                    emit_now      = 1'b1;
                    cnt_next      = fill_len_reg;
                    awaiting_next = 1'b0;
                    fill_len_next = '0;
                end else if (lit_left_reg != 8'd0) begin
                    emit_now      = 1'b1;
                    cnt_next      = 8'd1;
                    lit_left_next = lit_left_reg - 8'd1;
                end else if (!byte_reg[7]) begin
                    lit_left_next = byte_reg + 8'd1;
                end else if (byte_reg != NOOP_CODE) begin
                    // 257 - code, always 2..128
                    fill_len_next = 8'd1 - byte_reg;
                    awaiting_next = 1'b1;
                end
            end
            OP_DIV: begin
                // four restoring steps, quotient bits shift in from the right
                for (int i = 0; i < 4; i++) begin
                    trial = {r, q[15]};
                    q     = {q[14:0], 1'b0};
                    if (trial >= {1'b0, w_eff}) begin
                        trial = trial - {1'b0, w_eff};
                        q[0]  = 1'b1;
                    end
                    r = trial[8:0];
                end
                div_q_next = q;
                div_r_next = r;
            end
            OP_EMIT: begin
                if (out_free) begin
                    pos_next = pos_new;
                    if (done_flag) begin
                        active_next = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        step_next = step_reg + 4'd1;
        case (uw.br)
            BR_NEXT: begin
                step_next = step_reg + 4'd1;
            end
            BR_GOTO: begin
                step_next = uw.target;
            end
            BR_WAIT_IN: begin
                step_next = step_reg;
                if (in_fire && s_data.action == ACT_BYTE && active_reg) begin
                    step_next = uw.target;
                end
            end
            BR_TEST: begin
                step_next = emit_now ? step_reg + 4'd1 : uw.target;
            end
            BR_WAIT_OUT: begin
                step_next = out_free ? uw.target : step_reg;
            end
            default: begin
                step_next = STEP_FETCH;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg       <= STEP_FETCH;
            max_color_reg  <= 8'd255;
            rle_mode_reg   <= 1'b1;
            remap_en_reg   <= 1'b0;
            width_cfg_reg  <= 9'd8;
            height_cfg_reg <= 9'd8;
            pos_reg        <= '0;
            lit_left_reg   <= '0;
            fill_len_reg   <= '0;
            awaiting_reg   <= 1'b0;
            active_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            step_reg     <= step_next;
            pos_reg      <= pos_next;
            lit_left_reg <= lit_left_next;
            fill_len_reg <= fill_len_next;
            awaiting_reg <= awaiting_next;
            active_reg   <= active_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MAX_COLOR:    max_color_reg  <= cfg_wdata[7:0];
                    CFG_RLE_MODE:     rle_mode_reg   <= cfg_wdata[0];
                    CFG_REMAP_ENABLE: remap_en_reg   <= cfg_wdata[0];
                    CFG_GLYPH_WIDTH:  width_cfg_reg  <= cfg_wdata;
                    CFG_GLYPH_HEIGHT: height_cfg_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (uw.op == OP_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        div_q_reg <= div_q_next;
        div_r_reg <= div_r_next;
        if (in_fire) begin
            byte_reg <= s_data.data_byte;
        end
        if (uw.op == OP_TOTAL) begin
            total_reg <= 17'(w_eff * h_eff);
            color_reg <= color_clamp;
        end
        if (uw.op == OP_ADDR) begin
            // col is below 256 and the remainder of the divide
            prod_reg <= 17'(div_r_reg[7:0] * h_eff);
        end
        if (uw.op == OP_EMIT && out_free) begin
            m_data_reg <= out_item;
        end
    end

    // remap table, read in the total step ahead of use
    always_ff @(posedge aclk) begin
        if (in_fire && s_data.action == ACT_LOAD) begin
            remap_mem[s_data.remap_index] <= s_data.remap_value;
        end
        if (uw.op == OP_TOTAL) begin
            remap_rdata_reg <= remap_mem[color_clamp];
        end
    end

endmodule

`default_nettype wire

/* hdl/fgrd_checker.sv */
// Port-level checker for the glyph run-length decoder, bound to the top level.
`default_nettype none

module fgrd_checker
    import fgrd_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire in_item_t  s_data,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // results come from the sequencer's last step, never right after an input transfer
    a_no_fast_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared right after input transfer");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.run_count != 8'd0 && m_data.run_count <= 8'd128)
        else $error("run count out of range");

endmodule

bind font_glyph_rle_decoder_unit fgrd_checker u_fgrd_checker (.*);

`default_nettype wire

/* sim/tb_font_glyph_rle_decoder_unit.sv */
// Self-checking testbench for the glyph run-length decoder: directed and random streams.
module tb_font_glyph_rle_decoder_unit;
    import fgrd_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES = 32;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_wr_en = 1'b0;
    logic [2:0] cfg_index = CFG_MAX_COLOR;
    logic [8:0] cfg_wdata = '0;

    always #2 aclk = ~aclk;

    font_glyph_rle_decoder_unit dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    in_item_t stream_items[$];
    out_item_t pending_runs[$];
    out_item_t next_run;
    int mismatch_count = 0;
    int send_gap = 0;
    int take_gap = 0;
    int hold_left = 0;
    bit hold_armed = 0;
    bit hold_started = 0;
    bit quiet_tail = 0;
    int idle_cycles = 0;

    // decoder state as seen by the checker
    logic [16:0] decode_pos = '0;
    logic [7:0] literals_left = '0;
    logic [7:0] fill_len = '0;
    bit fill_color_next = 0;
    bit glyph_open = 0;
    logic [7:0] remap_mem [256];

    // register copies, reset values
    logic [7:0] max_color_q = 8'd255;
    bit rle_on = 1;
    bit remap_on = 0;
    logic [8:0] width_q = 9'd8;
    logic [8:0] height_q = 9'd8;

    function automatic int unsigned clip_dim(input logic [8:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM_DEF)
            return MAX_DIM_DEF;
        return v;
    endfunction

    // One accepted item: update decode state, queue the run it produces, if any.
    task automatic decode_glyph_item(input in_item_t it);
        int unsigned w, h, total, cnt, row, col;
        logic [31:0] addr;
        logic [7:0] color;
        bit makes_run;
        out_item_t run;
        makes_run = 0;
        cnt = 1;
        case (it.action)
            ACT_START: begin
                decode_pos = '0;
                literals_left = '0;
                fill_len = '0;
                fill_color_next = 0;
                glyph_open = 1;
            end
            ACT_LOAD: remap_mem[it.remap_index] = it.remap_value;
            ACT_BYTE: begin
                if (glyph_open) begin
                    w = clip_dim(width_q);
                    h = clip_dim(height_q);
                    total = w * h;
                    if (decode_pos >= total)
                        glyph_open = 0;
                    else if (!rle_on)
                        makes_run = 1;
                    else if (fill_color_next) begin
                        cnt = fill_len;
                        fill_color_next = 0;
                        fill_len = '0;
                        makes_run = 1;
                    end else if (literals_left != 0) begin
                        literals_left = literals_left - 8'd1;
                        makes_run = 1;
                    end else if (it.data_byte < 8'd128) begin
                        literals_left = it.data_byte + 8'd1;
                    end else if (it.data_byte != NOOP_CODE) begin
                        fill_len = 8'(9'd257 - it.data_byte);
                        fill_color_next = 1;
                    end
                    if (makes_run) begin
                        color = it.data_byte;
                        if (color > max_color_q)
                            color = max_color_q;
                        if (remap_on)
                            color = remap_mem[color];
                        if (cnt > total - decode_pos)
                            cnt = total - decode_pos;
                        row = decode_pos / w;
                        col = decode_pos % w;
                        addr = col * h + row;
                        run.pixel_value = color;
                        run.first_position = decode_pos[15:0];
                        run.first_address = addr[15:0];
                        run.run_count = cnt[7:0];
                        run.glyph_done = (decode_pos + cnt >= total);
                        decode_pos = 17'(decode_pos + cnt);
                        if (run.glyph_done)
                            glyph_open = 0;
                        pending_runs.push_back(run);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready)
                decode_glyph_item(s_data);
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (stream_items.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(0, 7);
                    s_valid <= 1'b0;
                end else begin
                    s_data <= stream_items.pop_front();
                    s_valid <= 1'b1;
                end
            end
        end
    end

    // monitor and result-side flow control
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            take_gap = 0;
            hold_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_runs.size() == 0) begin
                    $error("run transfer with nothing expected: %h", m_data);
                    mismatch_count++;
                end else begin
                    next_run = pending_runs.pop_front();
                    if (m_data.pixel_value !== next_run.pixel_value) begin
                        $error("pixel_value expected %0d got %0d",
                               next_run.pixel_value, m_data.pixel_value);
                        mismatch_count++;
                    end
                    if (m_data.first_position !== next_run.first_position) begin
                        $error("first_position expected %0d got %0d",
                               next_run.first_position, m_data.first_position);
                        mismatch_count++;
                    end
                    if (m_data.first_address !== next_run.first_address) begin
                        $error("first_address expected %0d got %0d",
                               next_run.first_address, m_data.first_address);
                        mismatch_count++;
                    end
                    if (m_data.run_count !== next_run.run_count) begin
                        $error("run_count expected %0d got %0d",
                               next_run.run_count, m_data.run_count);
                        mismatch_count++;
                    end
                    if (m_data.glyph_done !== next_run.glyph_done) begin
                        $error("glyph_done expected %0d got %0d",
                               next_run.glyph_done, m_data.glyph_done);
                        mismatch_count++;
                    end
                end
            end
            if (hold_armed && !hold_started) begin
                hold_started = 1;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (take_gap > 0) begin
                take_gap--;
                m_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                take_gap = $urandom_range(0, 7);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic in_item_t stream_item(input logic [1:0] act, input logic [7:0] b);
        in_item_t it;
        it.action = act;
        it.data_byte = b;
        it.remap_index = 8'($urandom_range(0, 255));
        it.remap_value = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // everything accepted, every run taken, then let no-result bytes finish
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (stream_items.size() != 0 || s_valid || pending_runs.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [8:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_MAX_COLOR:    max_color_q = val[7:0];
            CFG_RLE_MODE:     rle_on = val[0];
            CFG_REMAP_ENABLE: remap_on = val[0];
            CFG_GLYPH_WIDTH:  width_q = val;
            CFG_GLYPH_HEIGHT: height_q = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Well-formed glyph streams with random content, plus some noise.
    task automatic push_glyph_stream(input int n_items, input int unsigned total,
                                     input bit raw);
        int unsigned left;
        int unsigned code;
        int pushed;
        int pick;
        left = 0;
        pushed = 0;
        while (pushed < n_items) begin
            pick = $urandom_range(0, 99);
            if (left == 0 || pick < 3) begin
                stream_items.push_back(stream_item(ACT_START, 8'($urandom_range(0, 255))));
                left = total;
                pushed++;
            end else if (pick < 9) begin
                stream_items.push_back(stream_item(pick < 6 ? ACT_UNUSED : ACT_LOAD,
                                                   8'($urandom_range(0, 255))));
                pushed++;
            end else if (raw) begin
                stream_items.push_back(stream_item(ACT_BYTE, 8'($urandom_range(0, 255))));
                left--;
                pushed++;
            end else if (pick < 55) begin
                code = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                   : $urandom_range(0, 5);
                stream_items.push_back(stream_item(ACT_BYTE, 8'(code)));
                pushed++;
                for (int k = 0; k <= code && left > 0; k++) begin
                    stream_items.push_back(stream_item(ACT_BYTE,
                                                       8'($urandom_range(0, 255))));
                    left--;
                    pushed++;
                end
            end else if (pick < 92) begin
                code = $urandom_range(129, 255);
                stream_items.push_back(stream_item(ACT_BYTE, 8'(code)));
                stream_items.push_back(stream_item(ACT_BYTE, 8'($urandom_range(0, 255))));
                pushed += 2;
                left -= (257 - code < left) ? 257 - code : left;
            end else begin
                stream_items.push_back(stream_item(ACT_BYTE, NOOP_CODE));
                pushed++;
            end
        end
    endtask

    task automatic run_glyph_phase(input int n_items, input logic [8:0] wd,
                                   input logic [8:0] ht, input logic [7:0] maxc,
                                   input bit raw, input bit remap, input bit hold_off);
        logic [8:0] noise;
        noise = 9'($urandom_range(0, 511));
        // upper wdata bits beyond each register's width are don't-care
        write_reg(CFG_MAX_COLOR, {noise[0], maxc});
        write_reg(CFG_RLE_MODE, {noise[8:1], !raw});
        write_reg(CFG_REMAP_ENABLE, {noise[7:0], remap});
        write_reg(CFG_GLYPH_WIDTH, wd);
        write_reg(CFG_GLYPH_HEIGHT, ht);
        push_glyph_stream(n_items, clip_dim(wd) * clip_dim(ht), raw);
        if (hold_off)
            hold_armed = 1;
        wait_drained();
    endtask

    initial begin
        in_item_t it;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ignored before any start; unused action code
        stream_items.push_back(stream_item(ACT_BYTE, 8'h05));
        stream_items.push_back(stream_item(ACT_UNUSED, 8'h00));
        // two literals at the color extremes, no-op, then an oversized fill clipped
        stream_items.push_back(stream_item(ACT_START, 8'hFF));
        stream_items.push_back(stream_item(ACT_BYTE, 8'h01));
        stream_items.push_back(stream_item(ACT_BYTE, 8'h00));
        stream_items.push_back(stream_item(ACT_BYTE, 8'hFF));
        stream_items.push_back(stream_item(ACT_BYTE, NOOP_CODE));
        stream_items.push_back(stream_item(ACT_BYTE, 8'h81));
        stream_items.push_back(stream_item(ACT_BYTE, 8'hAA));
        // past the glyph end
        stream_items.push_back(stream_item(ACT_BYTE, 8'h7F));
        // shortest fill, then a literal packet left open
        stream_items.push_back(stream_item(ACT_START, 8'h00));
        stream_items.push_back(stream_item(ACT_BYTE, 8'hFF));
        stream_items.push_back(stream_item(ACT_BYTE, 8'h33));
        stream_items.push_back(stream_item(ACT_BYTE, 8'h02));
        stream_items.push_back(stream_item(ACT_BYTE, 8'h44));
        wait_drained();

        // raw bytes in the middle of a literal packet; packet resumes afterwards
        write_reg(CFG_RLE_MODE, 9'd0);
        stream_items.push_back(stream_item(ACT_BYTE, 8'h10));
        stream_items.push_back(stream_item(ACT_BYTE, 8'hFE));
        wait_drained();
        write_reg(CFG_RLE_MODE, 9'd1);
        stream_items.push_back(stream_item(ACT_BYTE, 8'h55));
        stream_items.push_back(stream_item(ACT_BYTE, 8'h66));
        stream_items.push_back(stream_item(ACT_BYTE, 8'hFD));
        stream_items.push_back(stream_item(ACT_BYTE, 8'h21));
        wait_drained();

        // glyph shrunk below the current position: byte dropped, glyph closes
        write_reg(CFG_GLYPH_WIDTH, 9'd2);
        write_reg(CFG_GLYPH_HEIGHT, 9'd2);
        stream_items.push_back(stream_item(ACT_BYTE, 8'h03));
        stream_items.push_back(stream_item(ACT_BYTE, 8'h09));
        wait_drained();

        // fill the whole remap table before any phase enables it
        for (int i = 0; i < REMAP_DEPTH; i++) begin
            it = stream_item(ACT_LOAD, 8'($urandom_range(0, 255)));
            it.remap_index = 8'(i);
            stream_items.push_back(it);
        end
        wait_drained();

        run_glyph_phase(25, 9'd8, 9'd8, 8'd255, 1'b0, 1'b0, 1'b0);
        run_glyph_phase(20, 9'd1, 9'd1, 8'd0, 1'b0, 1'b0, 1'b0);
        run_glyph_phase(30, 9'd256, 9'd3, 8'd100, 1'b0, 1'b1, 1'b1);
        run_glyph_phase(25, 9'd0, 9'd511, 8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0);
        run_glyph_phase(25, 9'd5, 9'd7, 8'd255, 1'b1, 1'b1, 1'b0);
        run_glyph_phase(20, 9'd300, 9'd256, 8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
        quiet_tail = 1;
        run_glyph_phase(30, 9'd13, 9'd9, 8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0);

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
hdl/fgrd_pkg.sv
hdl/font_glyph_rle_decoder_unit.sv
hdl/fgrd_checker.sv
sim/tb_font_glyph_rle_decoder_unit.sv
